@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the lookup block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define HKSL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define HKSL_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ src/hksl_pkg.sv @@
// ----------------------------------------------------------------------------
// hksl_pkg
// shared constants, types and codes of the hashed key lookup block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hksl_pkg;

   localparam int MAX_ENTRIES = 4096;
   localparam int PACK_COUNT  = 2;

   // fixed field widths
   localparam int PACK_W = 2;
   localparam int SLOT_W = 12;
   localparam int CNT_W  = 13;
   localparam int WORD_W = 32;
   localparam int BYTE_W = 8;

   // derived widths
   localparam int DEPTH  = PACK_COUNT * MAX_ENTRIES;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LH_W   = $clog2(MAX_ENTRIES + 1);
   localparam int MID_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   localparam logic [WORD_W-1:0] FNV_BASIS = 32'h811C9DC5;
   localparam logic [WORD_W-1:0] FNV_PRIME = 32'h01000193;
   localparam logic [WORD_W-1:0] DATA_BASE_OFS = 32'd16;
   localparam logic [WORD_W-1:0] ENTRY_BYTES   = 32'd12;

   // csr register indexes
   localparam logic [1:0] CSR_ENTRIES_PACK0 = 2'd0;
   localparam logic [1:0] CSR_ENTRIES_PACK1 = 2'd1;
   localparam logic [1:0] CSR_FORCE_MISS    = 2'd2;

   // request kinds
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [WORD_W-1:0] key_hash;
      logic [WORD_W-1:0] offset;
      logic [WORD_W-1:0] length;
   } entry_type;

   typedef struct packed {
      logic              valid;
      logic [PACK_W-1:0] pack;
      logic [LH_W-1:0]   count;
      logic [WORD_W-1:0] hash;
      logic              seen;
   } start_type;

   typedef struct packed {
      logic              valid;
      logic              hit;
      logic [WORD_W-1:0] offset;
      logic [WORD_W-1:0] length;
   } result_type;

endpackage

@@ src/hksl_ram.sv @@
// ----------------------------------------------------------------------------
// hksl_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hksl_ram #(
   parameter int DATA_W = 96,
   parameter int DEPTH  = 8192,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/hksl_hash.sv @@
// ----------------------------------------------------------------------------
// hksl_hash
// fnv-1a accumulator over the query text, one byte per cycle while byte_en is high
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hksl_hash (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              byte_en,
   input  logic [hksl_pkg::BYTE_W-1:0]       text_byte,
   input  logic                              last,
   output logic [hksl_pkg::WORD_W-1:0]       hash_next,
   output logic                              seen_next
);

   logic [hksl_pkg::WORD_W-1:0] hash_ff, hash_in;
   logic                        seen_ff, seen_in;
   logic                        ended_ff, ended_in;
   logic [hksl_pkg::WORD_W-1:0] mixed;
   logic                        take;

   // bytes after the terminating zero are ignored
   assign take  = !ended_ff && (text_byte != '0);
   assign mixed = hash_ff ^ hksl_pkg::WORD_W'(text_byte);

   always_comb begin
      hash_next = hash_ff;
      seen_next = seen_ff;
      if (take) begin
         hash_next = mixed * hksl_pkg::FNV_PRIME;
         seen_next = 1'b1;
      end
   end

   always_comb begin
      hash_in  = hash_ff;
      seen_in  = seen_ff;
      ended_in = ended_ff;
      if (byte_en) begin
         if (last) begin
            hash_in  = hksl_pkg::FNV_BASIS;
            seen_in  = 1'b0;
            ended_in = 1'b0;
         end else begin
            hash_in  = hash_next;
            seen_in  = seen_next;
            ended_in = ended_ff || (text_byte == '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff  <= hksl_pkg::FNV_BASIS;
         seen_ff  <= 1'b0;
         ended_ff <= 1'b0;
      end else begin
         hash_ff  <= hash_in;
         seen_ff  <= seen_in;
         ended_ff <= ended_in;
      end
   end

endmodule

@@ src/hksl_search.sv @@
// ----------------------------------------------------------------------------
// hksl_search
// binary search sequencer over one pack of the index memory
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hksl_search (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              force_miss,
   input  hksl_pkg::start_type               start,
   input  logic                              out_free,
   output logic                              idle,
   output logic                              rd_en,
   output logic [hksl_pkg::ADDR_W-1:0]       rd_addr,
   input  hksl_pkg::entry_type               rd_data,
   output hksl_pkg::result_type              result
);

   hksl_pkg::state_type state_ff, state_in;

   logic [hksl_pkg::LH_W-1:0]   lo_ff, lo_in;
   logic [hksl_pkg::LH_W-1:0]   hi_ff, hi_in;
   logic [hksl_pkg::MID_W-1:0]  mid_ff, mid_in;
   logic [hksl_pkg::WORD_W-1:0] hash_ff, hash_in;
   logic [hksl_pkg::PACK_W-1:0] pack_ff, pack_in;
   logic [hksl_pkg::WORD_W-1:0] base_ff, base_in;
   logic                        hit_ff, hit_in;
   logic [hksl_pkg::WORD_W-1:0] off_ff, off_in;
   logic [hksl_pkg::WORD_W-1:0] len_ff, len_in;

   logic [hksl_pkg::LH_W:0]     mid_sum;
   logic [hksl_pkg::MID_W-1:0]  mid_calc;
   logic [hksl_pkg::LH_W-1:0]   lo_next, hi_next;
   logic                        found, go;

   assign go       = start.valid && !force_miss && (start.count != '0) && start.seen;
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_calc = mid_sum[hksl_pkg::MID_W:1];

   // compare of the probed entry
   always_comb begin
      found   = 1'b0;
      lo_next = lo_ff;
      hi_next = hi_ff;
      if (rd_data.key_hash < hash_ff) begin
         lo_next = hksl_pkg::LH_W'(mid_ff) + hksl_pkg::LH_W'(1);
      end else if (rd_data.key_hash > hash_ff) begin
         hi_next = hksl_pkg::LH_W'(mid_ff);
      end else begin
         found = 1'b1;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hksl_pkg::ST_IDLE: begin
            if (start.valid) begin
               state_in = go ? hksl_pkg::ST_READ : hksl_pkg::ST_DONE;
            end
         end
         hksl_pkg::ST_READ: begin
            state_in = hksl_pkg::ST_CMP;
         end
         hksl_pkg::ST_CMP: begin
            if (found || !(lo_next < hi_next)) begin
               state_in = hksl_pkg::ST_DONE;
            end else begin
               state_in = hksl_pkg::ST_READ;
            end
         end
         hksl_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = hksl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hksl_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      mid_in  = mid_ff;
      hash_in = hash_ff;
      pack_in = pack_ff;
      base_in = base_ff;
      hit_in  = hit_ff;
      off_in  = off_ff;
      len_in  = len_ff;
      unique case (state_ff)
         hksl_pkg::ST_IDLE: begin
            if (start.valid) begin
               lo_in   = '0;
               hi_in   = start.count;
               hash_in = start.hash;
               pack_in = start.pack;
               base_in = hksl_pkg::WORD_W'(start.count) * hksl_pkg::ENTRY_BYTES
                         + hksl_pkg::DATA_BASE_OFS;
               hit_in  = 1'b0;
               off_in  = '0;
               len_in  = '0;
            end
         end
         hksl_pkg::ST_READ: begin
            mid_in = mid_calc;
         end
         hksl_pkg::ST_CMP: begin
            lo_in = lo_next;
            hi_in = hi_next;
            if (found) begin
               hit_in = 1'b1;
               off_in = base_ff + rd_data.offset;
               len_in = rd_data.length;
            end
         end
         default: begin
         end
      endcase
   end

   // outputs
   always_comb begin
      idle    = (state_ff == hksl_pkg::ST_IDLE);
      rd_en   = (state_ff == hksl_pkg::ST_READ);
      rd_addr = hksl_pkg::ADDR_W'(pack_ff) * hksl_pkg::ADDR_W'(hksl_pkg::MAX_ENTRIES)
                + hksl_pkg::ADDR_W'(mid_calc);
      result.valid  = (state_ff == hksl_pkg::ST_DONE) && out_free;
      result.hit    = hit_ff;
      result.offset = off_ff;
      result.length = len_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hksl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mid_ff  <= mid_in;
      hash_ff <= hash_in;
      pack_ff <= pack_in;
      base_ff <= base_in;
      hit_ff  <= hit_in;
      off_ff  <= off_in;
      len_ff  <= len_in;
   end

   `HKSL_ASSERT_IMP(a_miss_zero, clock, reset, result.valid && !result.hit, result.offset == '0 && result.length == '0)
   `HKSL_ASSERT_IMP(a_window_open, clock, reset, state_ff == hksl_pkg::ST_READ, lo_ff < hi_ff)
   `HKSL_ASSERT_NXT(a_read_then_cmp, clock, reset, rd_en, state_ff == hksl_pkg::ST_CMP)

endmodule

@@ src/hashed_key_sorted_index_lookup.sv @@
// ----------------------------------------------------------------------------
// hashed_key_sorted_index_lookup
// fnv-1a hashed text lookup in a sorted per-pack index by binary search
// ----------------------------------------------------------------------------
// a load or a non-final query byte leaves the search sequencer idle, and the next request
//   is accepted in the cycle after
// a final query byte runs a binary search, skipped under force_miss, a zero count or
//   empty text; each probe is a memory read then a compare, at most ceil(log2(count+1)) probes
// the single read port of the index memory sets the probe rate
// reset: synchronous, clears csr registers, hash state, sequencer and response valid; the
//   index memory is not cleared, entries read before written are undefined
`timescale 1ns / 1ps

module hashed_key_sorted_index_lookup (
   input  logic         clock,
   input  logic         reset,

   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   // [1:0] pack_select, [13:2] entry_slot, [45:14] entry_key_hash,
   // [77:46] entry_offset, [109:78] entry_length, [117:110] text_byte, rest zero
   input  logic [119:0] req_tdata,
   // [0] req_type
   input  logic         req_tuser,
   input  logic         req_tlast,

   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] clip_offset, [63:32] clip_length
   output logic [63:0]  rsp_tdata,
   // [0] hit
   output logic         rsp_tuser,

   // csr write port
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [12:0]  csr_wdata
);

   // request fields
   logic [hksl_pkg::PACK_W-1:0] pack_select;
   logic [hksl_pkg::SLOT_W-1:0] entry_slot;
   hksl_pkg::entry_type         entry_wr;
   logic [hksl_pkg::BYTE_W-1:0] text_byte;

   assign pack_select       = req_tdata[1:0];
   assign entry_slot        = req_tdata[13:2];
   assign entry_wr.key_hash = req_tdata[45:14];
   assign entry_wr.offset   = req_tdata[77:46];
   assign entry_wr.length   = req_tdata[109:78];
   assign text_byte         = req_tdata[117:110];

   // csr registers
   logic [hksl_pkg::CNT_W-1:0] entries0_ff, entries0_in;
   logic [hksl_pkg::CNT_W-1:0] entries1_ff, entries1_in;
   logic                       force_miss_ff, force_miss_in;

   always_comb begin
      entries0_in   = entries0_ff;
      entries1_in   = entries1_ff;
      force_miss_in = force_miss_ff;
      if (csr_we) begin
         unique case (csr_index)
            hksl_pkg::CSR_ENTRIES_PACK0: entries0_in   = csr_wdata;
            hksl_pkg::CSR_ENTRIES_PACK1: entries1_in   = csr_wdata;
            hksl_pkg::CSR_FORCE_MISS:    force_miss_in = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries0_ff   <= '0;
         entries1_ff   <= '0;
         force_miss_ff <= 1'b0;
      end else begin
         entries0_ff   <= entries0_in;
         entries1_ff   <= entries1_in;
         force_miss_ff <= force_miss_in;
      end
   end

   // handshake and request decode
   logic search_idle;
   logic req_fire;
   logic load_fire;
   logic query_fire;

   // requests are taken whenever the search sequencer is idle, even with a
   // response still waiting in the output register
   assign req_tready = search_idle;
   assign req_fire   = req_tvalid && req_tready;
   assign load_fire  = req_fire && (req_tuser == hksl_pkg::REQ_LOAD);
   assign query_fire = req_fire && (req_tuser == hksl_pkg::REQ_QUERY);

   // index memory write, out-of-range pack or slot is dropped
   logic                        wr_en;
   logic [hksl_pkg::ADDR_W-1:0] wr_addr;

   assign wr_en   = load_fire
                    && (32'(pack_select) < 32'(hksl_pkg::PACK_COUNT))
                    && (32'(entry_slot) < 32'(hksl_pkg::MAX_ENTRIES));
   assign wr_addr = hksl_pkg::ADDR_W'(pack_select) * hksl_pkg::ADDR_W'(hksl_pkg::MAX_ENTRIES)
                    + hksl_pkg::ADDR_W'(entry_slot);

   logic                        rd_en;
   logic [hksl_pkg::ADDR_W-1:0] rd_addr;
   hksl_pkg::entry_type         rd_data;

   hksl_ram #(
      .DATA_W ($bits(hksl_pkg::entry_type)),
      .DEPTH  (hksl_pkg::DEPTH),
      .ADDR_W (hksl_pkg::ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (entry_wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // text hashing
   logic [hksl_pkg::WORD_W-1:0] hash_next;
   logic                        seen_next;

   hksl_hash u_hash (
      .clock     (clock),
      .reset     (reset),
      .byte_en   (query_fire),
      .text_byte (text_byte),
      .last      (req_tlast),
      .hash_next (hash_next),
      .seen_next (seen_next)
   );

   // pack entry count, saturated to the index size; packs without a
   // register or beyond the pack count are absent
   logic [hksl_pkg::CNT_W-1:0] count_raw;
   logic [hksl_pkg::LH_W-1:0]  count_sat;

   always_comb begin
      case (pack_select)
         2'd0:    count_raw = entries0_ff;
         2'd1:    count_raw = entries1_ff;
         default: count_raw = '0;
      endcase
      if (32'(pack_select) >= 32'(hksl_pkg::PACK_COUNT)) begin
         count_raw = '0;
      end
      if (32'(count_raw) > 32'(hksl_pkg::MAX_ENTRIES)) begin
         count_sat = hksl_pkg::LH_W'(hksl_pkg::MAX_ENTRIES);
      end else begin
         count_sat = hksl_pkg::LH_W'(count_raw);
      end
   end

   hksl_pkg::start_type  start;
   hksl_pkg::result_type result;
   logic                 out_free;

   assign start.valid = query_fire && req_tlast;
   assign start.pack  = pack_select;
   assign start.count = count_sat;
   assign start.hash  = hash_next;
   assign start.seen  = seen_next;

   hksl_search u_search (
      .clock      (clock),
      .reset      (reset),
      .force_miss (force_miss_ff),
      .start      (start),
      .out_free   (out_free),
      .idle       (search_idle),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .result     (result)
   );

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_hit_ff, rsp_hit_in;
   logic [hksl_pkg::WORD_W-1:0] rsp_off_ff, rsp_off_in;
   logic [hksl_pkg::WORD_W-1:0] rsp_len_ff, rsp_len_in;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_off_in   = rsp_off_ff;
      rsp_len_in   = rsp_len_ff;
      if (result.valid) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = result.hit;
         rsp_off_in   = result.offset;
         rsp_len_in   = result.length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff <= rsp_hit_in;
      rsp_off_ff <= rsp_off_in;
      rsp_len_ff <= rsp_len_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = {rsp_len_ff, rsp_off_ff};

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the hashed key sorted index lookup: loads sorted
// per-pack indexes, streams query text through the fnv-1a hash and compares
// every lookup response against a cycle-free predictor of the search
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   import hksl_pkg::*;

   // no handshake on either channel for this many cycles ends the run
   localparam int WATCHDOG_LIMIT = 4000;
   // quiet cycles after the last response before a csr write or the verdict
   localparam int SETTLE_CYCLES = 40;
   localparam int POOL_SIZE = 24;

   // one request as the predictor sees it
   typedef struct packed {
      logic              kind;
      logic [PACK_W-1:0] pack;
      logic [SLOT_W-1:0] slot;
      logic [WORD_W-1:0] key;
      logic [WORD_W-1:0] offset;
      logic [WORD_W-1:0] length;
      logic [BYTE_W-1:0] tbyte;
      logic              last;
   } lookup_req_t;

   // one lookup response
   typedef struct packed {
      logic              hit;
      logic [WORD_W-1:0] offset;
      logic [WORD_W-1:0] length;
   } lookup_rsp_t;

   // query text of up to eight bytes, first byte in the low bits
   typedef struct packed {
      logic [3:0]  len;
      logic [63:0] chars;
   } text_t;

   logic          clock = 1'b0;
   logic          reset = 1'b1;

   logic          req_tvalid = 1'b0;
   logic          req_tready;
   // [1:0] pack_select, [13:2] entry_slot, [45:14] entry_key_hash,
   // [77:46] entry_offset, [109:78] entry_length, [117:110] text_byte, rest zero
   logic [119:0]  req_tdata = '0;
   // [0] req_type
   logic          req_tuser = 1'b0;
   logic          req_tlast = 1'b0;

   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   // [31:0] clip_offset, [63:32] clip_length
   logic [63:0]   rsp_tdata;
   // [0] hit
   logic          rsp_tuser;

   logic          csr_we = 1'b0;
   logic [1:0]    csr_index = '0;
   logic [CNT_W-1:0] csr_wdata = '0;

   // predictor state: index stores, hash accumulator and register copies
   logic [WORD_W-1:0] key_mem [DEPTH];
   logic [WORD_W-1:0] off_mem [DEPTH];
   logic [WORD_W-1:0] len_mem [DEPTH];
   bit                loaded [DEPTH];
   // number of consecutive loaded slots from slot 0, per pack
   int unsigned       prefix_len [PACK_COUNT];
   logic [WORD_W-1:0] hash_acc = FNV_BASIS;
   bit                any_text = 1'b0;
   bit                text_done = 1'b0;
   logic [CNT_W-1:0]  cnt_reg [PACK_COUNT];
   bit                miss_reg = 1'b0;

   lookup_rsp_t   pending_lookups [$];
   text_t         text_pool [$];
   logic [WORD_W-1:0] build_key [MAX_ENTRIES];

   int unsigned   requests_done = 0;
   int unsigned   mismatch_count = 0;
   int unsigned   quiet_cycles = 0;
   int unsigned   send_idle_pct = 0;
   int unsigned   rsp_stall_pct = 0;

   // handshakes seen in the low phase, acted on at the next rising edge
   bit            req_taken = 1'b0;
   bit            rsp_taken = 1'b0;
   lookup_rsp_t   rsp_seen;
   lookup_rsp_t   want;

   hashed_key_sorted_index_lookup uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------

   function automatic logic [WORD_W-1:0] fnv_mix(input logic [WORD_W-1:0] h,
                                                 input logic [BYTE_W-1:0] b);
      return (h ^ {24'd0, b}) * FNV_PRIME;
   endfunction

   function automatic logic [WORD_W-1:0] text_hash(input text_t t);
      logic [WORD_W-1:0] h;
      h = FNV_BASIS;
      for (int i = 0; i < t.len; i++) h = fnv_mix(h, t.chars[8*i +: 8]);
      return h;
   endfunction

   // entry count the search uses, saturated; packs without a register are absent
   function automatic int unsigned live_count(input logic [PACK_W-1:0] p);
      int unsigned c;
      c = 0;
      if (p == 2'd0) c = cnt_reg[0];
      else if (p == 2'd1) c = cnt_reg[1];
      if (c > MAX_ENTRIES) c = MAX_ENTRIES;
      return c;
   endfunction

   // applies one accepted request and queues the lookup response it causes
   function automatic void predict_lookup(input lookup_req_t r);
      int unsigned addr, row, cnt, lo, hi, mid;
      logic [WORD_W-1:0] base;
      lookup_rsp_t res;
      bit found;
      if (r.kind == REQ_LOAD) begin
         // loads to a pack without storage are dropped
         if (r.pack < PACK_COUNT) begin
            row = r.pack * MAX_ENTRIES;
            addr = row + r.slot;
            key_mem[addr] = r.key;
            off_mem[addr] = r.offset;
            len_mem[addr] = r.length;
            loaded[addr] = 1'b1;
            while (prefix_len[r.pack[0]] < MAX_ENTRIES && loaded[row + prefix_len[r.pack[0]]])
               prefix_len[r.pack[0]]++;
         end
         return;
      end
      // bytes after the zero terminator are not hashed
      if (!text_done) begin
         if (r.tbyte == 8'h00) text_done = 1'b1;
         else begin
            hash_acc = fnv_mix(hash_acc, r.tbyte);
            any_text = 1'b1;
         end
      end
      if (!r.last) return;
      res = '0;
      found = 1'b0;
      cnt = live_count(r.pack);
      if (!miss_reg && cnt != 0 && any_text) begin
         base = DATA_BASE_OFS + ENTRY_BYTES * cnt;
         row = r.pack * MAX_ENTRIES;
         lo = 0;
         hi = cnt;
         while (lo < hi && !found) begin
            mid = (lo + hi) / 2;
            addr = row + mid;
            if (key_mem[addr] < hash_acc) lo = mid + 1;
            else if (key_mem[addr] > hash_acc) hi = mid;
            else begin
               found = 1'b1;
               res.hit = 1'b1;
               res.offset = base + off_mem[addr];
               res.length = len_mem[addr];
            end
         end
      end
      pending_lookups.push_back(res);
      // the query state starts over after every final byte
      hash_acc = FNV_BASIS;
      any_text = 1'b0;
      text_done = 1'b0;
   endfunction

   // ------------------------------------------------------------------------
   // response check and watchdog
   // ------------------------------------------------------------------------

   always @(negedge clock) begin
      req_taken = req_tvalid && req_tready && !reset;
      rsp_taken = rsp_tvalid && rsp_tready && !reset;
      rsp_seen.hit = rsp_tuser;
      rsp_seen.offset = rsp_tdata[31:0];
      rsp_seen.length = rsp_tdata[63:32];
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         quiet_cycles = 0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         if (rsp_taken) begin
            if (pending_lookups.size() == 0) begin
               $display("%0t unexpected response: expected none actual hit %0d offset %h length %h",
                        $time, rsp_seen.hit, rsp_seen.offset, rsp_seen.length);
               mismatch_count++;
            end else begin
               want = pending_lookups.pop_front();
               if (rsp_seen.hit !== want.hit) begin
                  $display("%0t hit mismatch: expected %0d actual %0d",
                           $time, want.hit, rsp_seen.hit);
                  mismatch_count++;
               end
               if (rsp_seen.offset !== want.offset) begin
                  $display("%0t clip_offset mismatch: expected %h actual %h",
                           $time, want.offset, rsp_seen.offset);
                  mismatch_count++;
               end
               if (rsp_seen.length !== want.length) begin
                  $display("%0t clip_length mismatch: expected %h actual %h",
                           $time, want.length, rsp_seen.length);
                  mismatch_count++;
               end
            end
         end
         // watchdog: a hung handshake on either side ends the run
         if (req_taken || rsp_taken) quiet_cycles = 0;
         else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("%0t no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
               $display("SCOREBOARD MISMATCH");
               $finish;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // request driving
   // ------------------------------------------------------------------------

   function automatic lookup_req_t random_request();
      logic [127:0] noise;
      lookup_req_t r;
      noise = {$urandom, $urandom, $urandom, $urandom};
      r = noise[119:0];
      return r;
   endfunction

   // drives one request, waits for the handshake and feeds the predictor;
   // valid stays high afterwards so back-to-back requests need no gap
   task automatic send_request(input lookup_req_t r);
      bit took;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= r.kind;
      req_tlast <= r.last;
      req_tdata <= {2'b00, r.tbyte, r.length, r.offset, r.key, r.slot, r.pack};
      do begin
         @(negedge clock);
         took = req_tready;
         @(posedge clock);
      end while (!took);
      predict_lookup(r);
      // loads to an absent pack are dropped by the block and are not counted
      if (!(r.kind == REQ_LOAD && r.pack >= PACK_COUNT)) requests_done++;
   endtask

   task automatic send_load(input logic [PACK_W-1:0] p, input logic [SLOT_W-1:0] slot,
                            input logic [WORD_W-1:0] key, input logic [WORD_W-1:0] off,
                            input logic [WORD_W-1:0] len);
      lookup_req_t r;
      r = random_request();
      r.kind = REQ_LOAD;
      r.pack = p;
      r.slot = slot;
      r.key = key;
      r.offset = off;
      r.length = len;
      send_request(r);
   endtask

   // streams a query: the text bytes, then with tail > 0 a zero terminator
   // followed by tail-1 junk bytes; the last flag rides on the final request.
   // with wedge set, loads are slipped in between the bytes now and then
   task automatic send_query(input text_t t, input logic [PACK_W-1:0] p, input int tail,
                             input bit wedge);
      lookup_req_t r;
      int total;
      logic [PACK_W-1:0] lp;
      total = t.len + tail;
      for (int i = 0; i < total; i++) begin
         if (wedge && $urandom_range(29) == 0) begin
            lp = $urandom_range(3);
            send_load(lp, (lp == 2'd0) ? $urandom_range(63) : $urandom_range(MAX_ENTRIES - 1),
                      $urandom, $urandom, $urandom);
         end
         r = random_request();
         r.kind = REQ_QUERY;
         if (i < t.len) r.tbyte = t.chars[8*i +: 8];
         else if (i == t.len) r.tbyte = 8'h00;
         else r.tbyte = $urandom;
         r.last = (i == total - 1);
         if (r.last) begin
            r.pack = p;
            // never let the search reach a slot that was not loaded
            if (!miss_reg && p < PACK_COUNT && live_count(p) > prefix_len[p[0]])
               r.pack = {1'b1, 1'($urandom_range(1))};
         end
         send_request(r);
      end
   endtask

   function automatic text_t random_text();
      text_t t;
      t = '0;
      t.len = $urandom_range(1, 8);
      for (int i = 0; i < t.len; i++) t.chars[8*i +: 8] = $urandom_range(1, 255);
      return t;
   endfunction

   // waits until every response is in, then lets the block go quiet
   task automatic drain_lookups();
      req_tvalid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // writes all three registers back to back while the block is idle
   task automatic program_registers(input logic [CNT_W-1:0] c0, input logic [CNT_W-1:0] c1,
                                    input bit fm);
      logic [CNT_W-1:0] fm_word;
      drain_lookups();
      // only bit 0 of the force_miss word counts
      fm_word = $urandom;
      fm_word[0] = fm;
      csr_we <= 1'b1;
      csr_index <= CSR_ENTRIES_PACK0;
      csr_wdata <= c0;
      @(posedge clock);
      csr_index <= CSR_ENTRIES_PACK1;
      csr_wdata <= c1;
      @(posedge clock);
      csr_index <= CSR_FORCE_MISS;
      csr_wdata <= fm_word;
      @(posedge clock);
      csr_we <= 1'b0;
      cnt_reg[0] = c0;
      cnt_reg[1] = c1;
      miss_reg = fm;
   endtask

   // loads n sorted entries into pack p; keys are spread evenly over the hash
   // space and most pool text hashes replace the key of the slot they fall in
   task automatic load_index(input logic [PACK_W-1:0] p, input int n, input bit downward);
      logic [63:0] stride, wide;
      logic [WORD_W-1:0] span, h;
      int unsigned s;
      stride = 64'h1_0000_0000 / n;
      span = stride[31:0] - 32'd1;
      for (int i = 0; i < n; i++) begin
         wide = i * stride;
         build_key[i] = wide[31:0] + $urandom_range(span);
      end
      foreach (text_pool[k]) begin
         if ($urandom_range(3) != 0) begin
            h = text_hash(text_pool[k]);
            s = {32'd0, h} / stride;
            if (s >= n) s = n - 1;
            build_key[s] = h;
         end
      end
      for (int i = 0; i < n; i++) begin
         s = downward ? n - 1 - i : i;
         send_load(p, s, build_key[s],
                   ($urandom_range(15) == 0) ? 32'hFFFF_FFFF : $urandom,
                   ($urandom_range(15) == 0) ? 32'hFFFF_FFFF : $urandom);
      end
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // field extremes, every request kind and each miss reason
   task automatic test_directed();
      logic [WORD_W-1:0] ka, kb, lo_k, hi_k;
      text_t empty_text;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      empty_text = '0;
      ka = text_hash(text_pool[0]);
      kb = text_hash(text_pool[1]);
      lo_k = (ka < kb) ? ka : kb;
      hi_k = (ka < kb) ? kb : ka;
      // straight out of reset every pack is absent
      send_query(text_pool[0], 2'd0, 1, 1'b0);
      // loads to packs with no storage are dropped
      send_load(2'd2, $urandom, $urandom, $urandom, $urandom);
      send_load(2'd3, $urandom, $urandom, $urandom, $urandom);
      // pack 0: key extremes, offset that wraps past the data base, zero fields
      send_load(2'd0, 12'd0, 32'h0000_0000, $urandom, $urandom);
      send_load(2'd0, 12'd1, lo_k, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_load(2'd0, 12'd2, hi_k, 32'h0000_0000, 32'h0000_0000);
      send_load(2'd0, 12'd3, 32'hFFFF_FFFF, $urandom, $urandom);
      // pack 1: top slot and a single live entry
      send_load(2'd1, 12'hFFF, $urandom, $urandom, $urandom);
      send_load(2'd1, 12'd0, ka, $urandom, $urandom);
      program_registers(13'd4, 13'd1, 1'b0);
      // hit without terminator, hit with terminator, junk after the terminator
      send_query(text_pool[0], 2'd0, 0, 1'b0);
      send_query(text_pool[1], 2'd0, 1, 1'b0);
      send_query(text_pool[0], 2'd0, 2, 1'b0);
      // empty text misses; the single live entry of pack 1 hits
      send_query(empty_text, 2'd0, 1, 1'b0);
      send_query(text_pool[0], 2'd1, 0, 1'b0);
      // invalid pack numbers miss
      send_query(text_pool[0], 2'd2, 1, 1'b0);
      send_query(text_pool[0], 2'd3, 0, 1'b0);
      // force_miss wins over a match
      program_registers(13'd4, 13'd1, 1'b1);
      send_query(text_pool[1], 2'd0, 1, 1'b0);
      // zero count means the pack is absent
      program_registers(13'd0, 13'd1, 1'b0);
      send_query(text_pool[0], 2'd0, 0, 1'b0);
   endtask

   // pack 1 filled to capacity, searched at full count and above it
   task automatic test_full_index();
      send_idle_pct = 9;
      rsp_stall_pct = 9;
      load_index(2'd1, MAX_ENTRIES, 1'b0);
      program_registers(13'd4, 13'd4096, 1'b0);
      repeat (16) send_query(text_pool[$urandom_range(POOL_SIZE - 1)], 2'd1,
                             $urandom_range(1), 1'b0);
      // counts above capacity saturate for the search and the data base
      program_registers(13'd4, 13'h1FFF, 1'b0);
      repeat (8) send_query(text_pool[$urandom_range(POOL_SIZE - 1)], 2'd1,
                            $urandom_range(1), 1'b0);
      program_registers(13'd4, 13'd4097, 1'b0);
      repeat (4) send_query(random_text(), 2'd1, $urandom_range(1), 1'b0);
   endtask

   // one random phase: fresh pack 0 index, random register settings, then
   // mostly well-formed queries with some malformed ones and stray loads
   task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                    input bit miss_all, input int unsigned quota);
      int n0;
      int unsigned pick, stop_at;
      logic [CNT_W-1:0] c0, c1;
      text_t t;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      n0 = ($urandom_range(9) == 0) ? $urandom_range(200, 400) : $urandom_range(1, 40);
      load_index(2'd0, n0, $urandom_range(1));
      if (miss_all) begin
         // top value for pack 0, random for pack 1; nothing is searched under force_miss
         c0 = 13'h1FFF;
         c1 = $urandom;
      end else begin
         case ($urandom_range(3))
            0: c0 = 13'd0;
            1: c0 = n0;
            2: c0 = $urandom_range(1, n0);
            default: c0 = prefix_len[0];
         endcase
         case ($urandom_range(3))
            0: c1 = 13'd4096;
            1: c1 = $urandom_range(1, 8191);
            2: c1 = 13'd0;
            default: c1 = $urandom_range(1, 64);
         endcase
      end
      program_registers(c0, c1, miss_all);
      stop_at = requests_done + quota;
      while (requests_done < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            // well-formed query for a text the indexes know
            send_query(text_pool[$urandom_range(POOL_SIZE - 1)], $urandom_range(1),
                       $urandom_range(1), 1'b1);
         end else if (pick < 72) begin
            send_query(random_text(), $urandom_range(1), $urandom_range(1), 1'b1);
         end else if (pick < 84) begin
            // malformed: any pack, junk after the terminator, or empty text
            if ($urandom_range(2) == 0) t = '0;
            else t = text_pool[$urandom_range(POOL_SIZE - 1)];
            send_query(t, $urandom_range(3), $urandom_range(1, 4), 1'b1);
         end else if (pick < 92) begin
            // stray load into the live part of pack 0
            send_load(2'd0, $urandom_range(n0 - 1), $urandom, $urandom, $urandom);
         end else begin
            send_load($urandom_range(3), $urandom, $urandom, $urandom, $urandom);
         end
      end
   endtask

   initial begin
      text_t t;
      // single-byte texts at both byte extremes come first in the pool
      t = '0;
      t.len = 4'd1;
      t.chars[7:0] = 8'h01;
      text_pool.push_back(t);
      t.chars[7:0] = 8'hFF;
      text_pool.push_back(t);
      while (text_pool.size() < POOL_SIZE) text_pool.push_back(random_text());
      cnt_reg[0] = '0;
      cnt_reg[1] = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_full_index();
      test_random_phase(0, 0, 1'b0, 110);
      test_random_phase(63, 0, 1'b0, 110);
      test_random_phase(0, 63, 1'b0, 110);
      test_random_phase(9, 9, 1'b0, 110);
      test_random_phase(9, 9, 1'b1, 110);

      drain_lookups();
      if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
